// ===== rtl/gcfd_pkg.sv =====
// Shared types, constants and the read sequence table of the frame decoder.
// Used by the front end, the event queue, the back end and the top level.
// Depends on nothing.
package gcfd_pkg;

  localparam int PayloadDepth = 64;
  localparam int PayloadAw    = $clog2(PayloadDepth);

  localparam logic [7:0] Sync1      = 8'h55;
  localparam logic [7:0] Sync2      = 8'hAA;
  localparam logic [7:0] IdGps      = 8'h10;
  localparam logic [7:0] IdCompass  = 8'h20;
  localparam logic [7:0] IdVersion  = 8'h30;
  localparam logic [7:0] LenGps     = 8'h3A;
  localparam logic [7:0] LenCompass = 8'h06;
  localparam logic [7:0] LenVersion = 8'h0C;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Payload addresses the back end fetches.
  localparam int GpsMaskAddr     = 55;
  localparam int CompassMaskAddr = 4;
  localparam int SatAddr         = 48;
  localparam int FixTypeAddr     = 50;
  localparam int FixFlagsAddr    = 52;

  // Capture slots in the back end, in fetch order for a gps frame.
  localparam int NumSlots    = 36;
  localparam int SlotAw      = $clog2(NumSlots);
  localparam int SlotMask    = 0;
  localparam int SlotTime    = 1;
  localparam int SlotLon     = 5;
  localparam int SlotLat     = 9;
  localparam int SlotAlt     = 13;
  localparam int SlotVelN    = 17;
  localparam int SlotVelE    = 21;
  localparam int SlotDown    = 25;
  localparam int SlotDopN    = 29;
  localparam int SlotDopE    = 31;
  localparam int SlotSat     = 33;
  localparam int SlotFixType = 34;
  localparam int SlotFixFlag = 35;
  localparam int GpsReads     = 36;
  localparam int CompassReads = 5;

  localparam logic [7:0] FixType2d    = 8'd2;
  localparam logic [7:0] FixType3d    = 8'd3;
  localparam int         FixFlagDgps  = 1;
  localparam logic [3:0] HourBumpLimit = 4'd7;

  localparam logic [1:0] FIX_NONE = 2'd0;
  localparam logic [1:0] FIX_2D   = 2'd1;
  localparam logic [1:0] FIX_3D   = 2'd2;
  localparam logic [1:0] FIX_DIFF = 2'd3;

  typedef enum logic [1:0] {
    KIND_GPS     = 2'd0,
    KIND_COMPASS = 2'd1,
    KIND_VERSION = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT_SYNC1 = 3'd0,
    PH_HUNT_SYNC2 = 3'd1,
    PH_ID         = 3'd2,
    PH_LEN        = 3'd3,
    PH_PAYLOAD    = 3'd4,
    PH_CK_A       = 3'd5,
    PH_CK_B       = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_MAG,
    BK_CALC,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic                 en;
    logic [PayloadAw-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic payload_lock;
    logic queue_full;
  } front_stall_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] clock_res;
    logic [16:0] date;
    logic [31:0] lon_or_mag_x;
    logic [31:0] lat_or_mag_y;
    logic [31:0] alt_mm;
    logic [31:0] vel_north;
    logic [31:0] vel_east;
    logic [31:0] climb;
    logic [15:0] dop_north;
    logic [15:0] dop_east;
    logic [9:0]  sat_fix;
  } result_t;

  // Payload address fetched at a given step of the back end's read sequence.
  function automatic logic [PayloadAw-1:0] read_addr(kind_e kind, logic [SlotAw-1:0] step);
    logic [7:0] s;
    logic [7:0] a;
    s = 8'(step);
    if (kind == KIND_COMPASS) begin
      if (s == 8'(SlotMask)) a = 8'(CompassMaskAddr);
      else a = s - 8'(SlotTime);
    end else begin
      if (s == 8'(SlotMask)) a = 8'(GpsMaskAddr);
      else if (s < 8'(SlotVelN)) a = s - 8'(SlotTime);        // bytes 0..15
      else if (s < 8'(SlotDopN)) a = s + 8'd11;               // bytes 28..39
      else if (s < 8'(SlotSat)) a = s + 8'd15;                // bytes 44..47
      else if (s == 8'(SlotSat)) a = 8'(SatAddr);
      else if (s == 8'(SlotFixType)) a = 8'(FixTypeAddr);
      else a = 8'(FixFlagsAddr);
    end
    return PayloadAw'(a);
  endfunction

endpackage

// ===== rtl/gcfd_in_if.sv =====
// Byte input channel of the frame decoder: valid/ready handshake and one byte.
// No dependencies.
interface gcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

// ===== rtl/gcfd_out_if.sv =====
// Result channel of the frame decoder: valid/ready handshake and decoded fields.
// No dependencies.
interface gcfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        clock_res;
  logic [16:0]        date;
  logic signed [31:0] lon_or_mag_x;
  logic signed [31:0] lat_or_mag_y;
  logic signed [31:0] alt_mm;
  logic signed [31:0] vel_north;
  logic signed [31:0] vel_east;
  logic signed [31:0] climb;
  logic signed [15:0] dop_north;
  logic signed [15:0] dop_east;
  logic [9:0]         sat_fix;

  modport source (output valid, kind, clock_res, date, lon_or_mag_x, lat_or_mag_y, alt_mm,
                  vel_north, vel_east, climb, dop_north, dop_east, sat_fix, input ready);
  modport sink (input valid, kind, clock_res, date, lon_or_mag_x, lat_or_mag_y, alt_mm,
                vel_north, vel_east, climb, dop_north, dop_east, sat_fix, output ready);
endinterface

// ===== rtl/gcfd_front.sv =====
// Front end: frame sync, id/length checks, running sums and the payload store.
// Depends on gcfd_pkg.
module gcfd_front
  import gcfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [7:0]   byte_i,
  output logic         ready_o,
  input  front_stall_t stall_i,
  output logic         push_o,
  output kind_e        push_kind_o,
  input  rd_req_t      rd_req_i,
  output logic [7:0]   rd_data_o
);

  phase_e               phase_q, phase_d;
  kind_e                kind_q, kind_d;
  logic [5:0]           len_q, len_d;
  logic [PayloadAw-1:0] count_q, count_d;
  logic [7:0]           sum_a_q, sum_a_d;
  logic [7:0]           sum_b_q, sum_b_d;
  logic [7:0]           sum_a_add, sum_b_add;
  logic                 accept;
  logic                 mem_we;
  logic [7:0]           mem [PayloadDepth];
  logic [7:0]           rd_data_q;

  // Payload waits while the back end owns the frame; CK_B, on a full queue.
  assign ready_o = !((phase_q == PH_PAYLOAD) && stall_i.payload_lock) &&
                   !((phase_q == PH_CK_B) && stall_i.queue_full);
  assign accept  = valid_i && ready_o;

  assign sum_a_add = sum_a_q + byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    len_d   = len_q;
    count_d = count_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    push_o  = 1'b0;
    mem_we  = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_HUNT_SYNC1: begin
          if (byte_i == Sync1) phase_d = PH_HUNT_SYNC2;
        end
        PH_HUNT_SYNC2: begin
          if (byte_i == Sync2) begin
            sum_a_d = '0;
            sum_b_d = '0;
            phase_d = PH_ID;
          end else begin
            phase_d = PH_HUNT_SYNC1;
          end
        end
        PH_ID: begin
          phase_d = PH_LEN;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          if (byte_i == IdGps) kind_d = KIND_GPS;
          else if (byte_i == IdCompass) kind_d = KIND_COMPASS;
          else if (byte_i == IdVersion) kind_d = KIND_VERSION;
          else begin
            phase_d = PH_HUNT_SYNC1;
            sum_a_d = sum_a_q;
            sum_b_d = sum_b_q;
          end
        end
        PH_LEN: begin
          if (byte_i == LenGps || byte_i == LenCompass || byte_i == LenVersion) begin
            len_d   = byte_i[5:0];
            count_d = '0;
            sum_a_d = sum_a_add;
            sum_b_d = sum_b_add;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_HUNT_SYNC1;
          end
        end
        PH_PAYLOAD: begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          if (6'(count_d) >= len_q) phase_d = PH_CK_A;
        end
        PH_CK_A: begin
          phase_d = (byte_i == sum_a_q) ? PH_CK_B : PH_HUNT_SYNC1;
        end
        PH_CK_B: begin
          phase_d = PH_HUNT_SYNC1;
          push_o  = (byte_i == sum_b_q);
        end
        default: begin
          phase_d = PH_HUNT_SYNC1;
          sum_a_d = '0;
          sum_b_d = '0;
          count_d = '0;
          len_d   = '0;
        end
      endcase
    end
  end

  assign push_kind_o = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_SYNC1;
      kind_q  <= KIND_GPS;
      len_q   <= '0;
      count_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q] <= byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) rd_data_q <= mem[rd_req_i.addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/gcfd_queue.sv =====
// Short queue of good-frame events between the front end and the back end.
// Depends on gcfd_pkg.
module gcfd_queue
  import gcfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  kind_e push_kind_i,
  input  logic  pop_i,
  output kind_e pop_kind_o,
  output logic  empty_o,
  output logic  full_o
);

  kind_e                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == QueueCntW'(QueueDepth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_kind_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_kind_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== rtl/gcfd_back.sv =====
// Back end: fetches the payload bytes of a good frame, unmasks and decodes them,
// tracks the compass range and holds the result. Depends on gcfd_pkg.
module gcfd_back
  import gcfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       queue_empty_i,
  input  kind_e      pop_kind_i,
  output logic       pop_o,
  output rd_req_t    rd_req_o,
  input  logic [7:0] rd_data_i,
  output logic       reading_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  back_state_e       state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [SlotAw-1:0] step_q, step_d;
  logic [SlotAw-1:0] last_step;
  logic              cap_valid_q;
  logic [SlotAw-1:0] cap_slot_q;
  logic [7:0]        slot_q [NumSlots];
  logic [7:0]        ux [NumSlots];
  logic [7:0]        mask, r, cmask;
  logic signed [15:0] mag_x, mag_y;
  logic signed [15:0] x_max_q, x_min_q, y_max_q, y_min_q;
  logic signed [16:0] x_sum, y_sum, x_mid, y_mid;
  logic signed [17:0] dx, dy;
  logic [31:0]       t_word, down;
  logic [5:0]        day;
  logic [1:0]        fix;
  result_t           res_d, res_q;

  assign last_step = (kind_q == KIND_COMPASS) ? SlotAw'(CompassReads - 1)
                                              : SlotAw'(GpsReads - 1);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    step_d   = step_q;
    pop_o    = 1'b0;
    rd_req_o = '0;
    case (state_q)
      BK_IDLE: begin
        if (!queue_empty_i) begin
          pop_o   = 1'b1;
          kind_d  = pop_kind_i;
          step_d  = '0;
          state_d = (pop_kind_i == KIND_VERSION) ? BK_CALC : BK_READ;
        end
      end
      BK_READ: begin
        rd_req_o.en   = 1'b1;
        rd_req_o.addr = read_addr(kind_q, step_q);
        step_d        = step_q + 1'b1;
        if (step_q == last_step) state_d = BK_DRAIN;
      end
      BK_DRAIN: state_d = (kind_q == KIND_COMPASS) ? BK_MAG : BK_CALC;
      BK_MAG:   state_d = BK_CALC;
      BK_CALC:  state_d = BK_OUT;
      BK_OUT: begin
        if (res_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign reading_o   = (state_q == BK_READ);
  assign res_valid_o = (state_q == BK_OUT);
  assign res_o       = res_q;

  // Compass mask is scrambled from payload byte 4; gps uses byte 55 directly.
  assign r     = slot_q[SlotMask];
  assign cmask = {r[4:1], r[7:4] ^ r[3:0]} ^ {r[0], 3'b000, r[0], 3'b000};
  assign mask  = (kind_q == KIND_COMPASS) ? cmask : r;

  always_comb begin
    for (int i = 0; i < NumSlots; i++) ux[i] = slot_q[i] ^ mask;
  end

  assign mag_x = {ux[SlotTime + 1], ux[SlotTime]};
  assign mag_y = {ux[SlotTime + 3], ux[SlotTime + 2]};

  // Midpoints truncate toward zero, as a signed halving does.
  assign x_sum = {x_max_q[15], x_max_q} + {x_min_q[15], x_min_q};
  assign y_sum = {y_max_q[15], y_max_q} + {y_min_q[15], y_min_q};
  assign x_mid = $signed(x_sum + {16'b0, x_sum[16]}) >>> 1;
  assign y_mid = $signed(y_sum + {16'b0, y_sum[16]}) >>> 1;
  assign dx    = {{2{mag_x[15]}}, mag_x} - {x_mid[16], x_mid};
  assign dy    = {{2{mag_y[15]}}, mag_y} - {y_mid[16], y_mid};

  assign t_word = {ux[SlotTime + 3], ux[SlotTime + 2], ux[SlotTime + 1], ux[SlotTime]};
  assign down   = {ux[SlotDown + 3], ux[SlotDown + 2], ux[SlotDown + 1], ux[SlotDown]};
  assign day    = {1'b0, t_word[20:16]} + {5'b0, (t_word[15:12] > HourBumpLimit)};

  always_comb begin
    if (ux[SlotFixType] == FixType2d) fix = FIX_2D;
    else if (ux[SlotFixType] == FixType3d) fix = FIX_3D;
    else fix = FIX_NONE;
    if (fix != FIX_NONE && ux[SlotFixFlag][FixFlagDgps]) fix = FIX_DIFF;
  end

  always_comb begin
    res_d      = '0;
    res_d.kind = kind_q;
    case (kind_q)
      KIND_GPS: begin
        res_d.clock_res    = t_word[15:0];
        res_d.date         = {t_word[31:25], t_word[24:21], day};
        res_d.lon_or_mag_x = {ux[SlotLon + 3], ux[SlotLon + 2], ux[SlotLon + 1], ux[SlotLon]};
        res_d.lat_or_mag_y = {ux[SlotLat + 3], ux[SlotLat + 2], ux[SlotLat + 1], ux[SlotLat]};
        res_d.alt_mm       = {ux[SlotAlt + 3], ux[SlotAlt + 2], ux[SlotAlt + 1], ux[SlotAlt]};
        res_d.vel_north    = {ux[SlotVelN + 3], ux[SlotVelN + 2], ux[SlotVelN + 1],
                              ux[SlotVelN]};
        res_d.vel_east     = {ux[SlotVelE + 3], ux[SlotVelE + 2], ux[SlotVelE + 1],
                              ux[SlotVelE]};
        res_d.climb        = (down == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - down);
        res_d.dop_north    = {ux[SlotDopN + 1], ux[SlotDopN]};
        res_d.dop_east     = {ux[SlotDopE + 1], ux[SlotDopE]};
        res_d.sat_fix      = {slot_q[SlotSat], fix};
      end
      KIND_COMPASS: begin
        res_d.lon_or_mag_x = {{14{dx[17]}}, dx};
        res_d.lat_or_mag_y = {{14{dy[17]}}, dy};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      kind_q      <= KIND_GPS;
      step_q      <= '0;
      cap_valid_q <= 1'b0;
      x_max_q     <= '0;
      x_min_q     <= '0;
      y_max_q     <= '0;
      y_min_q     <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      step_q      <= step_d;
      cap_valid_q <= rd_req_o.en;
      if (state_q == BK_MAG) begin
        if (mag_x > x_max_q) x_max_q <= mag_x;
        if (mag_x < x_min_q) x_min_q <= mag_x;
        if (mag_y > y_max_q) y_max_q <= mag_y;
        if (mag_y < y_min_q) y_min_q <= mag_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cap_slot_q <= step_q;
    if (cap_valid_q) slot_q[cap_slot_q] <= rd_data_i;
    if (state_q == BK_CALC) res_q <= res_d;
  end

endmodule

// ===== rtl/gps_compass_frame_decoder_core.sv =====
// Top level of the gps/compass frame decoder.
// Depends on gcfd_pkg, gcfd_in_if, gcfd_out_if, gcfd_front, gcfd_queue, gcfd_back.
//
// Usage:
//   rx_i carries one received byte per transaction (valid/ready). res_o carries
//   one decoded result per good frame: kind, gps time/date, position, altitude,
//   velocities, climb, dops and satellite/fix, or compass x/y centered on the
//   tracked range midpoints. Fields a frame kind does not define read as zero.
//   Bytes are taken one per cycle while the decoder is ready. After the last checksum byte of a
//   good frame the back end fetches the stored payload one byte per cycle:
//   36 fetches for gps, 5 for compass, none for version. The result is valid
//   after the queue pop, the fetches, the last capture, the compass range update
//   (compass only) and the result register; version skips the fetches and capture.
//   Header, id and length bytes of the next frame are accepted meanwhile;
//   its payload bytes wait until the fetches are done.
//   A stalled result holds res_o steady; the next frame may then complete and
//   wait in the queue, and the payload bytes of the frame after it stall.
//   Reset returns the decoder to hunting for the header, clears the running
//   sums and the compass range; the payload memory is not cleared.
module gps_compass_frame_decoder_core
  import gcfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gcfd_in_if.sink    rx_i,
  gcfd_out_if.source res_o
);

  front_stall_t stall;
  logic         push, pop, q_empty, q_full, reading;
  kind_e        push_kind, pop_kind;
  rd_req_t      rd_req;
  logic [7:0]   rd_data;
  result_t      res;

  assign stall.payload_lock = !q_empty || reading;
  assign stall.queue_full   = q_full;

  gcfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (rx_i.valid),
    .byte_i      (rx_i.rx_byte),
    .ready_o     (rx_i.ready),
    .stall_i     (stall),
    .push_o      (push),
    .push_kind_o (push_kind),
    .rd_req_i    (rd_req),
    .rd_data_o   (rd_data)
  );

  gcfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_kind_i (push_kind),
    .pop_i       (pop),
    .pop_kind_o  (pop_kind),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  gcfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .pop_kind_i    (pop_kind),
    .pop_o         (pop),
    .rd_req_o      (rd_req),
    .rd_data_i     (rd_data),
    .reading_o     (reading),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_o         (res)
  );

  assign res_o.kind         = res.kind;
  assign res_o.clock_res    = res.clock_res;
  assign res_o.date         = res.date;
  assign res_o.lon_or_mag_x = $signed(res.lon_or_mag_x);
  assign res_o.lat_or_mag_y = $signed(res.lat_or_mag_y);
  assign res_o.alt_mm       = $signed(res.alt_mm);
  assign res_o.vel_north    = $signed(res.vel_north);
  assign res_o.vel_east     = $signed(res.vel_east);
  assign res_o.climb        = $signed(res.climb);
  assign res_o.dop_north    = $signed(res.dop_north);
  assign res_o.dop_east     = $signed(res.dop_east);
  assign res_o.sat_fix      = res.sat_fix;

endmodule
